[rtl/assert_macros.svh]
// Assertion helpers used by the field extractor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASRT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASRT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ngga_pkg.sv]
package ngga_pkg;

  // ASCII codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Field capacities and degree split
  localparam logic [4:0] LAT_LEN   = 5'd10;
  localparam logic [4:0] LON_LEN   = 5'd11;
  localparam logic [4:0] SAT_CAP   = 5'd16;
  localparam logic [4:0] DEG_SHIFT = 5'd8;

  localparam int ALTITUDE_WIDTH_DEF = 15;
  localparam int POS_W              = 4;

  // Result field codes
  localparam logic [2:0] FC_LAT = 3'd0;
  localparam logic [2:0] FC_NS  = 3'd1;
  localparam logic [2:0] FC_LON = 3'd2;
  localparam logic [2:0] FC_EW  = 3'd3;
  localparam logic [2:0] FC_SAT = 3'd4;
  localparam logic [2:0] FC_ALT = 3'd5;

  // One result from the parser; tail marks the altitude unit, which can open the padding run
  typedef struct packed {
    logic             valid;
    logic [2:0]       code;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
    logic             tail;
  } ngga_res_t;

endpackage

[rtl/ngga_parser.sv]
module ngga_parser #(
  parameter int ALTITUDE_WIDTH = ngga_pkg::ALTITUDE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_char,
  output ngga_pkg::ngga_res_t res
);
  import ngga_pkg::*;

  // Header tracker, one-hot
  typedef enum logic [7:0] {
    HS_IDLE = 8'b0000_0001,
    HS_G1   = 8'b0000_0010,
    HS_P    = 8'b0000_0100,
    HS_G2   = 8'b0000_1000,
    HS_G3   = 8'b0001_0000,
    HS_A    = 8'b0010_0000,
    HS_ANY  = 8'b0100_0000,
    HS_BODY = 8'b1000_0000
  } hs_t;

  // Comma-separated field numbers within the sentence body
  localparam logic [3:0] FN_TIME = 4'd0;
  localparam logic [3:0] FN_LAT  = 4'd1;
  localparam logic [3:0] FN_NS   = 4'd2;
  localparam logic [3:0] FN_LON  = 4'd3;
  localparam logic [3:0] FN_EW   = 4'd4;
  localparam logic [3:0] FN_FIX  = 4'd5;
  localparam logic [3:0] FN_SAT  = 4'd6;
  localparam logic [3:0] FN_HDOP = 4'd7;
  localparam logic [3:0] FN_ALT  = 4'd8;
  localparam logic [3:0] FN_UNIT = 4'd9;

  localparam logic [4:0] ALT_CAP = 5'(ALTITUDE_WIDTH - 2);

  hs_t        hs_r, hs_nxt;
  logic [3:0] fn_r, fn_nxt;
  logic [4:0] co_r, co_nxt;
  logic       ad_r, ad_nxt;

  logic [4:0] len_w;
  logic [2:0] code_w;

  assign len_w  = (fn_r == FN_LAT) ? LAT_LEN : LON_LEN;
  assign code_w = (fn_r == FN_LAT) ? FC_LAT : FC_LON;

  // Next state and the single result of this item
  always_comb begin
    hs_nxt = hs_r;
    fn_nxt = fn_r;
    co_nxt = co_r;
    ad_nxt = ad_r;
    res    = '0;
    if (rx_char == CH_DOLLAR) begin
      hs_nxt = HS_G1;
      fn_nxt = FN_TIME;
      co_nxt = '0;
      ad_nxt = 1'b0;
    end else begin
      unique case (hs_r)
        HS_IDLE: hs_nxt = HS_IDLE;
        HS_G1:   hs_nxt = (rx_char == CH_G) ? HS_P  : HS_IDLE;
        HS_P:    hs_nxt = (rx_char == CH_P) ? HS_G2 : HS_IDLE;
        HS_G2:   hs_nxt = (rx_char == CH_G) ? HS_G3 : HS_IDLE;
        HS_G3:   hs_nxt = (rx_char == CH_G) ? HS_A  : HS_IDLE;
        HS_A:    hs_nxt = (rx_char == CH_A) ? HS_ANY : HS_IDLE;
        HS_ANY: begin
          hs_nxt = HS_BODY;
          fn_nxt = FN_TIME;
          co_nxt = '0;
          ad_nxt = 1'b0;
        end
        HS_BODY: begin
          if (ad_r) begin
            // direction letter, whatever it is
            res.valid = 1'b1;
            res.code  = (fn_r == FN_LAT) ? FC_NS : FC_EW;
            res.pos   = '0;
            res.ch    = rx_char;
            ad_nxt    = 1'b0;
            fn_nxt    = fn_r + 4'd1;
          end else begin
            unique case (fn_r)
              FN_TIME, FN_FIX, FN_HDOP: begin
                if (rx_char == CH_COMMA) begin
                  fn_nxt = fn_r + 4'd1;
                  co_nxt = '0;
                end
              end
              FN_LAT, FN_LON: begin
                if (rx_char == CH_COMMA) begin
                  // degree space goes in on the closing comma
                  res.valid = 1'b1;
                  res.code  = code_w;
                  res.pos   = POS_W'(len_w - DEG_SHIFT);
                  res.ch    = CH_SPACE;
                  ad_nxt    = 1'b1;
                  co_nxt    = '0;
                end else if (co_r < len_w) begin
                  res.valid = 1'b1;
                  res.code  = code_w;
                  res.pos   = (co_r < (len_w - DEG_SHIFT)) ? POS_W'(co_r)
                                                           : POS_W'(co_r + 5'd1);
                  res.ch    = rx_char;
                  co_nxt    = co_r + 5'd1;
                end
              end
              FN_NS, FN_EW: fn_nxt = fn_r + 4'd1;
              FN_SAT: begin
                if (rx_char == CH_COMMA) begin
                  fn_nxt = FN_HDOP;
                  co_nxt = '0;
                end else if (co_r < SAT_CAP) begin
                  res.valid = 1'b1;
                  res.code  = FC_SAT;
                  res.pos   = POS_W'(co_r);
                  res.ch    = rx_char;
                  co_nxt    = co_r + 5'd1;
                end
              end
              FN_ALT: begin
                res.code = FC_ALT;
                res.pos  = POS_W'(co_r);
                if (rx_char == CH_COMMA) begin
                  res.valid = 1'b1;
                  res.ch    = CH_SPACE;
                  fn_nxt    = FN_UNIT;
                end else if (co_r < ALT_CAP) begin
                  res.valid = 1'b1;
                  res.ch    = rx_char;
                  co_nxt    = co_r + 5'd1;
                end
              end
              FN_UNIT: begin
                // unit letter; padding follows in the output stage
                res.valid = 1'b1;
                res.code  = FC_ALT;
                res.pos   = POS_W'(co_r + 5'd1);
                res.ch    = rx_char;
                res.tail  = 1'b1;
                hs_nxt    = HS_IDLE;
                fn_nxt    = FN_TIME;
                co_nxt    = '0;
                ad_nxt    = 1'b0;
              end
              default: begin
                hs_nxt = HS_IDLE;
                fn_nxt = FN_TIME;
                co_nxt = '0;
                ad_nxt = 1'b0;
              end
            endcase
          end
        end
        default: hs_nxt = HS_IDLE;
      endcase
    end
  end

  // State registers, stepped once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= HS_IDLE;
      fn_r <= FN_TIME;
      co_r <= '0;
      ad_r <= 1'b0;
    end else if (step) begin
      hs_r <= hs_nxt;
      fn_r <= fn_nxt;
      co_r <= co_nxt;
      ad_r <= ad_nxt;
    end
  end

endmodule

[rtl/nmea_gga_field_extractor.sv]
// Channel | Ports                                          | Meaning
// in      | in_valid/in_ready, in_rx_char                  | one received character per item
// out     | out_valid/out_ready, out_field_code,           | one field character per item
//         | out_char_position, out_out_char,               |
//         | out_sentence_done, out_last_of_run             |
// An input character is parsed straight from the input register; a result it causes is
// loaded into the output register when the parser steps on that character.
// It gives no result or one, except the altitude unit, which also opens a run of space
// padding: up to ALTITUDE_WIDTH-1 results in all, one per cycle unless the output stalls.
// Characters causing no result keep flowing while a result waits at the output; one that
// causes a result waits for a free output slot, behind a padding run and any stalls.
// Synchronous active-low reset returns the parser to waiting for a dollar sign.
module nmea_gga_field_extractor #(
  parameter int ALTITUDE_WIDTH = ngga_pkg::ALTITUDE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_field_code,
  output logic [3:0] out_char_position,
  output logic [7:0] out_out_char,
  output logic       out_sentence_done,
  output logic       out_last_of_run
);
  import ngga_pkg::*;
  `include "assert_macros.svh"

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(ALTITUDE_WIDTH - 1);

  logic             in_valid_r;
  logic [7:0]       in_char_r;
  logic             out_valid_r;
  logic [2:0]       out_code_r;
  logic [POS_W-1:0] out_pos_r;
  logic [7:0]       out_char_r;
  logic             tail_r;
  logic             burst_r;

  ngga_res_t res;
  logic      slot_free;
  logic      advance;
  logic      out_fire;

  // Parser steps when its result, if any, has a free output slot
  assign out_fire  = out_valid_r && out_ready;
  assign slot_free = !out_valid_r || (out_ready && !burst_r);
  assign advance   = in_valid_r && (!res.valid || slot_free);
  assign in_ready  = !in_valid_r || advance;

  ngga_parser #(
    .ALTITUDE_WIDTH(ALTITUDE_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .rx_char(in_char_r),
    .res    (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_rx_char;
    end
  end

  // Output register and padding run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      burst_r     <= 1'b0;
    end else if (out_fire && burst_r) begin
      burst_r <= (out_pos_r + 4'd1) != LAST_POS;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
      burst_r     <= res.tail && (res.pos != LAST_POS);
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire && burst_r) begin
      out_pos_r  <= out_pos_r + 4'd1;
      out_char_r <= CH_SPACE;
    end else if (advance && res.valid) begin
      out_code_r <= res.code;
      out_pos_r  <= res.pos;
      out_char_r <= res.ch;
      tail_r     <= res.tail;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_field_code    = out_code_r;
  assign out_char_position = out_pos_r;
  assign out_out_char      = out_char_r;
  assign out_last_of_run   = !burst_r;
  assign out_sentence_done = tail_r && !burst_r;

  // Padding steps one position per taken item
  `ASRT_NXT(a_pad_step, out_fire && burst_r,
            out_valid_r && out_char_r == CH_SPACE && out_pos_r == $past(out_pos_r) + 4'd1)
  // A waiting input item is held in place
  `ASRT_NXT(a_in_hold, in_valid_r && !advance,
            in_valid_r && in_char_r == $past(in_char_r))
  // Sentence end lands on the last altitude position
  `ASRT_IMP(a_done_pos, out_valid_r && out_sentence_done,
            out_pos_r == LAST_POS && out_code_r == FC_ALT && out_last_of_run)

endmodule

[bench/nmea_gga_field_extractor_test.sv]
`timescale 1ns / 100ps

module nmea_gga_field_extractor_test;
  import ngga_pkg::*;

  localparam int ALT_W       = ALTITUDE_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 40;

  // Parser position while matching the sentence header
  typedef enum logic [2:0] {
    HS_IDLE, HS_WANT_G1, HS_WANT_P, HS_WANT_G2, HS_WANT_G3, HS_WANT_A, HS_SKIP, HS_BODY
  } hdr_stage_t;

  // Comma-separated fields of a GGA body, in order
  typedef enum logic [3:0] {
    F_TIME, F_LAT, F_NS, F_LON, F_EW, F_FIX, F_SAT, F_HDOP, F_ALT, F_UNIT
  } gga_field_t;

  typedef struct packed {
    logic [2:0] code;
    logic [3:0] pos;
    logic [7:0] ch;
    logic       done;
    logic       last;
  } field_char_t;

  // Tracks the parser state and the field characters still owed by the block
  class gga_scoreboard;
    hdr_stage_t  hdr;
    gga_field_t  fld;
    logic [4:0]  offset;
    bit          want_dir;
    field_char_t run_q[$];
    field_char_t due_q[$];
    int          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      hdr      = HS_IDLE;
      fld      = F_TIME;
      offset   = '0;
      want_dir = 1'b0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void emit(logic [2:0] code, int pos, logic [7:0] ch);
      field_char_t r;
      r.code = code;
      r.pos  = pos[3:0];
      r.ch   = ch;
      r.done = 1'b0;
      r.last = 1'b0;
      run_q.push_back(r);
    endfunction

    // Work out the field characters caused by one accepted item
    function void note_char(logic [7:0] c);
      field_char_t tmp;
      int len;
      int pos;
      int p;
      logic [2:0] code;
      run_q.delete();
      if (c == CH_DOLLAR) begin
        restart();
        hdr = HS_WANT_G1;
      end else begin
        case (hdr)
          HS_WANT_G1: hdr = (c == CH_G) ? HS_WANT_P  : HS_IDLE;
          HS_WANT_P:  hdr = (c == CH_P) ? HS_WANT_G2 : HS_IDLE;
          HS_WANT_G2: hdr = (c == CH_G) ? HS_WANT_G3 : HS_IDLE;
          HS_WANT_G3: hdr = (c == CH_G) ? HS_WANT_A  : HS_IDLE;
          HS_WANT_A:  hdr = (c == CH_A) ? HS_SKIP    : HS_IDLE;
          HS_SKIP: begin
            hdr      = HS_BODY;
            fld      = F_TIME;
            offset   = '0;
            want_dir = 1'b0;
          end
          HS_BODY: begin
            if (want_dir) begin
              // Whatever follows the comma is the direction letter
              emit((fld == F_LAT) ? FC_NS : FC_EW, 0, c);
              want_dir = 1'b0;
              fld      = gga_field_t'(fld + 1);
            end else begin
              case (fld)
                F_TIME, F_FIX, F_HDOP: begin
                  if (c == CH_COMMA) begin
                    fld    = gga_field_t'(fld + 1);
                    offset = '0;
                  end
                end
                F_LAT, F_LON: begin
                  len  = (fld == F_LAT) ? LAT_LEN : LON_LEN;
                  code = (fld == F_LAT) ? FC_LAT : FC_LON;
                  if (c == CH_COMMA) begin
                    // degree space goes out even for a short field
                    emit(code, len - DEG_SHIFT, CH_SPACE);
                    want_dir = 1'b1;
                    offset   = '0;
                  end else if (offset < len) begin
                    pos = (offset < len - DEG_SHIFT) ? offset : offset + 1;
                    emit(code, pos, c);
                    offset++;
                  end
                end
                F_NS, F_EW: fld = gga_field_t'(fld + 1);
                F_SAT: begin
                  if (c == CH_COMMA) begin
                    fld    = F_HDOP;
                    offset = '0;
                  end else if (offset < SAT_CAP) begin
                    emit(FC_SAT, offset, c);
                    offset++;
                  end
                end
                F_ALT: begin
                  if (c == CH_COMMA) begin
                    emit(FC_ALT, offset, CH_SPACE);
                    fld = F_UNIT;
                  end else if (offset < ALT_W - 2) begin
                    emit(FC_ALT, offset, c);
                    offset++;
                  end
                end
                F_UNIT: begin
                  // unit letter, then pad to the end of the altitude text
                  pos = offset + 1;
                  emit(FC_ALT, pos, c);
                  for (p = pos + 1; p < ALT_W; p++) emit(FC_ALT, p, CH_SPACE);
                  tmp = run_q.pop_back();
                  tmp.done = 1'b1;
                  run_q.push_back(tmp);
                  restart();
                end
                default: restart();
              endcase
            end
          end
          default: hdr = HS_IDLE;
        endcase
      end
      if (run_q.size() > 0) begin
        tmp = run_q.pop_back();
        tmp.last = 1'b1;
        run_q.push_back(tmp);
      end
      foreach (run_q[i]) due_q.push_back(run_q[i]);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted result with the oldest outstanding one
    function void check_result(field_char_t got);
      field_char_t want;
      if (due_q.size() == 0) begin
        flag($sformatf("unexpected item: code %0d pos %0d char %02h done %0b last %0b",
                       got.code, got.pos, got.ch, got.done, got.last));
      end else begin
        want = due_q.pop_front();
        if (got.code !== want.code || got.pos !== want.pos || got.ch !== want.ch ||
            got.done !== want.done || got.last !== want.last)
          flag($sformatf({"mismatch: expected code %0d pos %0d char %02h done %0b last %0b,",
                          " got code %0d pos %0d char %02h done %0b last %0b"},
                         want.code, want.pos, want.ch, want.done, want.last,
                         got.code, got.pos, got.ch, got.done, got.last));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_char = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_field_code;
  logic [3:0] out_char_position;
  logic [7:0] out_out_char;
  logic       out_sentence_done;
  logic       out_last_of_run;

  gga_scoreboard sb;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          counted = 0;
  int          cycles = 0;
  logic [7:0]  sentence_q[$];

  nmea_gga_field_extractor #(.ALTITUDE_WIDTH(ALT_W)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_char        (in_rx_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_field_code    (out_field_code),
    .out_char_position (out_char_position),
    .out_out_char      (out_out_char),
    .out_sentence_done (out_sentence_done),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check accepted items, stall at random
  always @(posedge clk) begin : result_side
    field_char_t got;
    if (rst_n && out_valid && out_ready) begin
      got.code = out_field_code;
      got.pos  = out_char_position;
      got.ch   = out_out_char;
      got.done = out_sentence_done;
      got.last = out_last_of_run;
      sb.check_result(got);
    end
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function logic [7:0] any_but_dollar();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_DOLLAR);
    return c;
  endfunction

  // Mostly digits and points, sometimes any byte that cannot end the field
  function logic [7:0] field_char();
    logic [7:0] c;
    if ($urandom_range(9) < 7) begin
      c = ($urandom_range(10) == 10) ? 8'h2E : 8'(8'h30 + $urandom_range(9));
    end else begin
      do c = 8'($urandom_range(255)); while (c == CH_DOLLAR || c == CH_COMMA);
    end
    return c;
  endfunction

  function void put_field(int n);
    repeat (n) sentence_q.push_back(field_char());
    sentence_q.push_back(CH_COMMA);
  endfunction

  task send_char(input logic [7:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_char <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(c);
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    counted += s.len();
  endtask

  // Hold the sender off until the block owes nothing more
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // One GGA sentence with random content; some broken off or with a bad header
  task send_sentence();
    string hdr_text;
    int    bad;
    int    keep;
    logic [7:0] c;
    hdr_text = "GPGGA";
    bad = ($urandom_range(9) == 0) ? $urandom_range(4) : -1;
    sentence_q.delete();
    sentence_q.push_back(CH_DOLLAR);
    for (int i = 0; i < 5; i++) sentence_q.push_back((i == bad) ? any_but_dollar() : hdr_text[i]);
    sentence_q.push_back(any_but_dollar());
    put_field($urandom_range(10));
    // latitude, direction, skipped separator
    put_field($urandom_range(13));
    c = ($urandom_range(1) == 0) ? "N" : "S";
    sentence_q.push_back(($urandom_range(1) == 0) ? c : any_but_dollar());
    sentence_q.push_back(($urandom_range(4) != 0) ? CH_COMMA : any_but_dollar());
    // longitude, direction, skipped separator
    put_field($urandom_range(14));
    c = ($urandom_range(1) == 0) ? "E" : "W";
    sentence_q.push_back(($urandom_range(1) == 0) ? c : any_but_dollar());
    sentence_q.push_back(($urandom_range(4) != 0) ? CH_COMMA : any_but_dollar());
    put_field($urandom_range(2));
    put_field(($urandom_range(3) == 0) ? $urandom_range(18) : $urandom_range(1, 2));
    put_field($urandom_range(4));
    put_field(($urandom_range(3) == 0) ? $urandom_range(10, 15) : $urandom_range(1, 6));
    sentence_q.push_back(($urandom_range(9) < 7) ? 8'h4D : any_but_dollar());
    if ($urandom_range(99) < 15) begin
      keep = $urandom_range(1, sentence_q.size() - 1);
      while (sentence_q.size() > keep) void'(sentence_q.pop_back());
    end
    foreach (sentence_q[i]) send_char(sentence_q[i]);
    counted += sentence_q.size();
    // line noise between sentences
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(255)));
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles often, receiver stalls more
    in_idle_pct  = 29;
    out_idle_pct = 61;

    // Extremes, header mismatch, then a sentence with every numeric field empty
    send_char(8'h00);
    send_char(8'hFF);
    send_text("$GPX");
    send_text("$GPGGA");
    send_char(8'hFF);
    send_text(",,");
    send_char(8'h80);
    send_text(",,E,,,,,M");
    counted += 3;
    drain();

    while (counted < 150) send_sentence();
    drain();

    in_idle_pct  = 61;
    out_idle_pct = 29;
    while (counted < 300) send_sentence();
    drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (counted < 450) send_sentence();
    drain();

    if (sb.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
